@@ design/bpr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpr_pkg;

  localparam int unsigned LenWidth   = 5;
  localparam int unsigned PosWidth   = 4;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned CountWidth = 32;
  localparam int unsigned RegWidth   = 64;
  localparam int unsigned TableWidth = 128;
  localparam int unsigned IndexWidth = 3;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [IndexWidth-1:0] {
    REG_PATTERN_LENGTH   = 3'd0,
    REG_PATTERN_LOW      = 3'd1,
    REG_PATTERN_HIGH     = 3'd2,
    REG_REPLACEMENT_LOW  = 3'd3,
    REG_REPLACEMENT_HIGH = 3'd4
  } reg_index_e;

  typedef enum logic [1:0] {
    CMD_REPLACE     = 2'd0,
    CMD_PREFIX_BYTE = 2'd1,
    CMD_PREFIX_FLUSH = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [LenWidth-1:0]   len;
    logic [TableWidth-1:0] pattern;
    logic [TableWidth-1:0] replacement;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [PosWidth-1:0]   last_idx;
    logic [ByteWidth-1:0]  data;
    logic [CountWidth-1:0] total;
  } cmd_t;

  function automatic logic [ByteWidth-1:0] pick_byte(
    input logic [TableWidth-1:0] bytes,
    input logic [PosWidth-1:0]   idx
  );
    pick_byte = bytes[{idx, 3'b000} +: ByteWidth];
  endfunction

endpackage

`default_nettype wire

@@ design/bpr_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bpr_pkg::IndexWidth-1:0]  cfg_index_i,
  input  wire logic [bpr_pkg::RegWidth-1:0]    cfg_data_i,
  output bpr_pkg::cfg_t                        cfg_o
);

  bpr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpr_pkg::REG_PATTERN_LENGTH: cfg_d.len = cfg_data_i[bpr_pkg::LenWidth-1:0];
        bpr_pkg::REG_PATTERN_LOW: cfg_d.pattern[63:0] = cfg_data_i;
        bpr_pkg::REG_PATTERN_HIGH: cfg_d.pattern[127:64] = cfg_data_i;
        bpr_pkg::REG_REPLACEMENT_LOW: cfg_d.replacement[63:0] = cfg_data_i;
        bpr_pkg::REG_REPLACEMENT_HIGH: cfg_d.replacement[127:64] = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.len         <= bpr_pkg::LenWidth'(1);
      cfg_q.pattern     <= '0;
      cfg_q.replacement <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bpr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_front #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bpr_pkg::cfg_t                  cfg_i,
  input  wire logic                           accept_i,
  input  wire logic                           mode_i,
  input  wire logic [bpr_pkg::ByteWidth-1:0]  data_byte_i,
  output logic                                push_o,
  output bpr_pkg::cmd_t                       cmd_o
);

  logic [bpr_pkg::PosWidth-1:0]   pos_q, pos_d;
  logic [bpr_pkg::CountWidth-1:0] cnt_q, cnt_d;
  logic [bpr_pkg::LenWidth-1:0]   len;
  logic [bpr_pkg::LenWidth-1:0]   next_pos;
  logic [bpr_pkg::CountWidth-1:0] cnt_inc;
  logic                           hit;
  logic                           complete;

  always_comb begin
    priority if (cfg_i.len == '0) begin
      len = bpr_pkg::LenWidth'(1);
    end else if (cfg_i.len > bpr_pkg::LenWidth'(MAX_PATTERN)) begin
      len = bpr_pkg::LenWidth'(MAX_PATTERN);
    end else begin
      len = cfg_i.len;
    end
  end

  assign hit      = data_byte_i == bpr_pkg::pick_byte(cfg_i.pattern, pos_q);
  assign next_pos = {1'b0, pos_q} + bpr_pkg::LenWidth'(1);
  assign complete = hit && (next_pos >= len);
  assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + bpr_pkg::CountWidth'(1);

  always_comb begin
    pos_d           = pos_q;
    cnt_d           = cnt_q;
    push_o          = 1'b0;
    cmd_o.kind      = bpr_pkg::CMD_PREFIX_BYTE;
    cmd_o.last_idx  = pos_q;
    cmd_o.data      = data_byte_i;
    cmd_o.total     = cnt_q;
    if (accept_i) begin
      priority if (mode_i) begin
        push_o     = 1'b1;
        cmd_o.kind = bpr_pkg::CMD_PREFIX_FLUSH;
        pos_d      = '0;
        cnt_d      = '0;
      end else if (complete) begin
        push_o         = 1'b1;
        cmd_o.kind     = bpr_pkg::CMD_REPLACE;
        cmd_o.last_idx = bpr_pkg::PosWidth'(len - bpr_pkg::LenWidth'(1));
        cmd_o.total    = cnt_inc;
        pos_d          = '0;
        cnt_d          = cnt_inc;
      end else if (hit) begin
        pos_d = next_pos[bpr_pkg::PosWidth-1:0];
      end else begin
        push_o = 1'b1;
        pos_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bpr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire bpr_pkg::cmd_t  cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output bpr_pkg::cmd_t       cmd_o
);

  localparam int unsigned PtrWidth = $clog2(bpr_pkg::QueueDepth);
  localparam int unsigned CntWidth = $clog2(bpr_pkg::QueueDepth + 1);

  bpr_pkg::cmd_t        mem_q [bpr_pkg::QueueDepth];
  logic [PtrWidth-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CntWidth'(bpr_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrWidth'(bpr_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrWidth'(bpr_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ design/bpr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bpr_pkg::cfg_t                    cfg_i,
  input  wire logic                             cmd_valid_i,
  input  wire bpr_pkg::cmd_t                    cmd_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [bpr_pkg::ByteWidth-1:0]         out_byte_o,
  output logic                                  is_data_o,
  output logic [bpr_pkg::CountWidth-1:0]        match_total_o,
  output logic                                  last_o
);

  logic [bpr_pkg::PosWidth-1:0]   idx_q, idx_d;
  logic                           valid_q, valid_d;
  logic [bpr_pkg::ByteWidth-1:0]  byte_q, byte_d;
  logic                           data_q, data_d;
  logic [bpr_pkg::CountWidth-1:0] total_q;
  logic                           last_q, last_d;
  logic                           advance;

  assign advance = cmd_valid_i && (!valid_q || !out_stall_i);
  assign last_d  = idx_q == cmd_i.last_idx;
  assign pop_o   = advance && last_d;

  always_comb begin
    data_d = 1'b1;
    unique case (cmd_i.kind)
      bpr_pkg::CMD_REPLACE: byte_d = bpr_pkg::pick_byte(cfg_i.replacement, idx_q);
      bpr_pkg::CMD_PREFIX_BYTE: byte_d = last_d ? cmd_i.data
                                                : bpr_pkg::pick_byte(cfg_i.pattern, idx_q);
      bpr_pkg::CMD_PREFIX_FLUSH: begin
        byte_d = last_d ? '0 : bpr_pkg::pick_byte(cfg_i.pattern, idx_q);
        data_d = !last_d;
      end
      default: byte_d = '0;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (advance) begin
      idx_d   = last_d ? '0 : idx_q + bpr_pkg::PosWidth'(1);
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q  <= byte_d;
      data_q  <= data_d;
      total_q <= cmd_i.total;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign is_data_o     = data_q;
  assign match_total_o = total_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

@@ design/byte_pattern_replacer_top.sv @@
// Channel   Direction  Handshake               Word
// in        input      in_valid_i / in_stall_o  mode_i, data_byte_i
// out       output     out_valid_o / out_stall_i out_byte_o, is_data_o, match_total_o, last_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An input word is classified in the cycle it is accepted, even while the back end is busy.
// Each result word leaves the output register one per cycle while out_stall_i is low, so
// an input word that causes n results (up to 16) occupies the back end until all n leave.
// A two-entry command queue between the front and back ends sets how far input runs ahead.
// Reset is asynchronous and active low; no clearing pass follows it.
// Input stalls only while the command queue is full.
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_replacer_top #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            mode_i,
  input  wire logic [7:0]                      data_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [7:0]                           out_byte_o,
  output logic                                 is_data_o,
  output logic [31:0]                          match_total_o,
  output logic                                 last_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bpr_pkg::IndexWidth-1:0]  cfg_index_i,
  input  wire logic [63:0]                     cfg_data_i
);

  bpr_pkg::cfg_t cfg;
  bpr_pkg::cmd_t push_cmd;
  bpr_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          full;
  logic          head_valid;
  logic          accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  bpr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bpr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  bpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_data_o     (is_data_o),
    .match_total_o (match_total_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

@@ design/bpr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  out_byte_o,
  input wire logic        is_data_o,
  input wire logic [31:0] match_total_o,
  input wire logic        last_o
);

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_data_o) && $stable(match_total_o) && $stable(last_o))
    else $error("stalled output word changed");

  // The count report closes its run and carries no stream byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_data_o |-> last_o && out_byte_o == 8'd0)
    else $error("count report malformed");

  // Words of one run follow back to back with a single total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && $stable(match_total_o))
    else $error("run broken or total changed within a run");

endmodule

bind byte_pattern_replacer_top bpr_checker u_bpr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .out_byte_o    (out_byte_o),
  .is_data_o     (is_data_o),
  .match_total_o (match_total_o),
  .last_o        (last_o)
);

`default_nettype wire
